// File: hdl/ufr_pkg.sv
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types, codes and the bytewise CRC-16/XMODEM update for the framed
// packet receiver.
// ----------------------------------------------------------------------------
package ufr_pkg;

    localparam logic [7:0]  START_BYTE  = 8'h02;
    localparam logic [7:0]  FOOTER_BYTE = 8'h03;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_TYPE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LENGTH    = 8'd1;

    localparam logic [7:0] EXPECTED_TYPE_RESET = 8'h32;
    localparam logic [7:0] MIN_LENGTH_RESET    = 8'd6;

    localparam logic       KIND_DATA    = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_TOO_SHORT = 3'd1;
    localparam logic [2:0] STATUS_BAD_TYPE  = 3'd2;
    localparam logic [2:0] STATUS_BAD_FOOT  = 3'd3;
    localparam logic [2:0] STATUS_BAD_CRC   = 3'd4;

    typedef struct packed {
        logic [7:0] expected_type;
        logic [7:0] min_length;
    } ufr_cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [31:0] value_mask;
    } ufr_result_t;

    // MSB-first CRC-16 update over one byte, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data_in);
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: hdl/uart_frame_receiver_crc16.sv
// ----------------------------------------------------------------------------
// uart_frame_receiver_crc16
// Framed serial byte receiver with CRC-16/XMODEM check, payload streaming
// and an end-of-frame verdict.
//
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   s_tdata[7:0] rx_byte
// m_*      out  m_tvalid / m_tready   m_tdata data_byte,status,value_mask
//                                     m_tuser kind
// cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle while s_tready is high; the decode is one pass of logic into
// the output register, or into the skid entry while the output is stalled.
// s_tready drops only while the skid entry holds a result (m_tready low
// with the output register full); it is registered.
// cfg_ready is always high. Reset clears frame state and loads the
// register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module uart_frame_receiver_crc16
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [47:0]                      m_tdata,   // [7:0] data_byte, [10:8] status,
                                                        // [42:11] value_mask, rest zero
    output logic                             m_tuser,   // [0] kind
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ufr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                       cfg_data
);
    import ufr_pkg::*;

    ufr_cfg_t    cfg_reg;
    ufr_cfg_t    cfg_next;
    logic        s_accept;
    logic        res_valid;
    ufr_result_t res;
    ufr_result_t out_res;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            if (cfg_index == REG_EXPECTED_TYPE)
                cfg_next.expected_type = cfg_data;
            else if (cfg_index == REG_MIN_LENGTH)
                cfg_next.min_length = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_type <= EXPECTED_TYPE_RESET;
            cfg_reg.min_length    <= MIN_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ufr_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_accept),
        .in_byte   (s_tdata),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ufr_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {5'b0, out_res.value_mask, out_res.status, out_res.data_byte};
    assign m_tuser = out_res.kind;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("skid entry full with output register empty");

    a_verdict_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_VERDICT) |-> (out_res.data_byte == 8'h00))
        else $error("verdict carries a data byte");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_DATA) |->
        (out_res.status == STATUS_OK && out_res.value_mask == 32'h0))
        else $error("payload transaction carries verdict fields");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_res.status <= STATUS_BAD_CRC))
        else $error("status code out of range");

endmodule

// File: hdl/ufr_parser.sv
// ----------------------------------------------------------------------------
// ufr_parser
// Frame state and per-byte decode: index tracking, CRC, mask capture,
// payload pass-through and end-of-frame verdict.
// ----------------------------------------------------------------------------
module ufr_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    input  ufr_pkg::ufr_cfg_t    cfg,
    output logic                 res_valid,
    output ufr_pkg::ufr_result_t res
);
    import ufr_pkg::*;

    logic        in_frame_reg,     in_frame_next;
    logic [8:0]  byte_index_reg,   byte_index_next;
    logic [8:0]  end_index_reg,    end_index_next;
    logic [15:0] running_crc_reg,  running_crc_next;
    logic [15:0] received_crc_reg, received_crc_next;
    logic [31:0] mask_word_reg,    mask_word_next;
    logic [7:0]  type_seen_reg,    type_seen_next;
    logic [7:0]  length_seen_reg,  length_seen_next;

    logic [8:0]  len_ext;
    logic [8:0]  len_p1;
    logic [8:0]  len_p2;
    logic [8:0]  len_p3;
    logic        close_frame;

    assign len_ext = {1'b0, length_seen_next};
    assign len_p1  = len_ext + 9'd1;
    assign len_p2  = len_ext + 9'd2;
    assign len_p3  = len_ext + 9'd3;

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        byte_index_next   = byte_index_reg;
        end_index_next    = end_index_reg;
        running_crc_next  = running_crc_reg;
        received_crc_next = received_crc_reg;
        mask_word_next    = mask_word_reg;
        type_seen_next    = type_seen_reg;
        length_seen_next  = length_seen_reg;
        close_frame       = 1'b0;
        res_valid         = 1'b0;
        res.kind          = KIND_DATA;
        res.data_byte     = 8'h00;
        res.status        = STATUS_OK;
        res.value_mask    = 32'h0;

        if (in_valid && !in_frame_reg)
        begin
            if (in_byte == START_BYTE)
            begin
                in_frame_next     = 1'b1;
                byte_index_next   = 9'd1;
                end_index_next    = 9'd0;
                running_crc_next  = 16'h0;
                received_crc_next = 16'h0;
                mask_word_next    = 32'h0;
                type_seen_next    = 8'h0;
                length_seen_next  = 8'h0;
            end
        end
        else if (in_valid)
        begin
            if (byte_index_reg == 9'd1)
            begin
                length_seen_next = in_byte;
                end_index_next   = {1'b0, in_byte} + 9'd4;
            end
            if (byte_index_reg == 9'd2)
                type_seen_next = in_byte;
            unique case (byte_index_reg)
                9'd3:    mask_word_next[31:24] = in_byte;
                9'd4:    mask_word_next[23:16] = in_byte;
                9'd5:    mask_word_next[15:8]  = in_byte;
                9'd6:    mask_word_next[7:0]   = in_byte;
                default: mask_word_next        = mask_word_reg;
            endcase
            if (byte_index_reg >= 9'd2 && byte_index_reg <= len_p1)
                running_crc_next = crc16_byte(running_crc_reg, in_byte);
            if (byte_index_reg == len_p2)
                received_crc_next[15:8] = in_byte;
            if (byte_index_reg == len_p3)
                received_crc_next[7:0] = in_byte;

            close_frame = (byte_index_reg >= 9'd2) && (byte_index_reg == end_index_next);

            if (close_frame)
            begin
                res_valid      = 1'b1;
                res.kind       = KIND_VERDICT;
                res.value_mask = mask_word_next;
                priority if (length_seen_next < cfg.min_length)
                    res.status = STATUS_TOO_SHORT;
                else if (type_seen_next != cfg.expected_type)
                    res.status = STATUS_BAD_TYPE;
                else if (in_byte != FOOTER_BYTE)
                    res.status = STATUS_BAD_FOOT;
                else if (running_crc_next != received_crc_next)
                    res.status = STATUS_BAD_CRC;
                else
                    res.status = STATUS_OK;
                in_frame_next   = 1'b0;
                byte_index_next = 9'd0;
            end
            else
            begin
                byte_index_next = byte_index_reg + 9'd1;
                if (byte_index_reg >= 9'd7 && byte_index_reg <= len_p1)
                begin
                    res_valid     = 1'b1;
                    res.data_byte = in_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg     <= 1'b0;
            byte_index_reg   <= 9'd0;
            end_index_reg    <= 9'd0;
            running_crc_reg  <= 16'h0;
            received_crc_reg <= 16'h0;
            mask_word_reg    <= 32'h0;
            type_seen_reg    <= 8'h0;
            length_seen_reg  <= 8'h0;
        end
        else
        begin
            in_frame_reg     <= in_frame_next;
            byte_index_reg   <= byte_index_next;
            end_index_reg    <= end_index_next;
            running_crc_reg  <= running_crc_next;
            received_crc_reg <= received_crc_next;
            mask_word_reg    <= mask_word_next;
            type_seen_reg    <= type_seen_next;
            length_seen_reg  <= length_seen_next;
        end
    end

endmodule

// File: hdl/ufr_out_buf.sv
// ----------------------------------------------------------------------------
// ufr_out_buf
// Output register with a skid entry; input side ready is registered.
// ----------------------------------------------------------------------------
module ufr_out_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ufr_pkg::ufr_result_t in_res,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ufr_pkg::ufr_result_t out_res
);
    import ufr_pkg::*;

    logic        out_valid_reg,  out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    ufr_result_t out_reg,        out_next;
    ufr_result_t skid_reg,       skid_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = in_res;
                out_valid_next = in_valid;
            end
        end
        else if (in_valid)
        begin
            skid_next       = in_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule
